// ===== design/dfr_pkg.sv =====
package dfr_pkg;

    // frame geometry
    localparam int FRAME_BYTES = 8;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int LEN_W       = $clog2(FRAME_BYTES + 2);
    localparam int BYTE_W      = 8;
    localparam int FLAG_W      = 5;

    // frame byte positions
    localparam int POS_CMD  = 1;
    localparam int POS_P3   = 4;
    localparam int POS_CSUM = FRAME_BYTES - 2;

    // delimiter and command codes
    localparam logic [BYTE_W-1:0] DELIM       = 8'hF5;
    localparam logic [BYTE_W-1:0] CMD_RECOG   = 8'h0B;
    localparam logic [BYTE_W-1:0] CMD_ENROLL1 = 8'h01;
    localparam logic [BYTE_W-1:0] CMD_ENROLL2 = 8'h02;
    localparam logic [BYTE_W-1:0] CMD_ENROLL3 = 8'h03;
    localparam logic [BYTE_W-1:0] CMD_DELETE  = 8'h05;
    localparam logic [BYTE_W-1:0] CMD_CANCEL  = 8'hC3;

    // sticky flag bits
    localparam int FLG_RECOG   = 0;
    localparam int FLG_ENROLL1 = 1;
    localparam int FLG_ENROLL2 = 2;
    localparam int FLG_ENROLL3 = 3;
    localparam int FLG_DELETE  = 4;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    typedef enum logic {
        OP_BYTE  = 1'b0,
        OP_CLEAR = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_ACCEPT = 2'd1,
        EV_REJECT = 2'd2
    } t_event;

    typedef logic [FRAME_BYTES-1:0][BYTE_W-1:0] t_frame;

    // one queued job: a status result or a frame to forward
    typedef struct packed {
        logic              fwd;
        t_event            ev;
        logic [BYTE_W-1:0] rc;
        logic [FLAG_W-1:0] flags;
        t_frame            frame;
    } t_entry;

endpackage

// ===== design/dfr_if.sv =====
interface dfr_rx_if;
    import dfr_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic [BYTE_W-1:0] rx_byte;
    logic [FLAG_W-1:0] clear_mask;

    modport source (output valid, op, rx_byte, clear_mask, input ready);
    modport sink   (input valid, op, rx_byte, clear_mask, output ready);
endinterface

interface dfr_tx_if;
    import dfr_pkg::*;

    logic              valid;
    logic              ready;
    logic              is_forward;
    logic [BYTE_W-1:0] tx_byte;
    logic              last;
    logic [1:0]        frame_event;
    logic [BYTE_W-1:0] resp_code;
    logic [FLAG_W-1:0] flags;

    modport source (output valid, is_forward, tx_byte, last, frame_event, resp_code, flags,
                    input ready);
    modport sink   (input valid, is_forward, tx_byte, last, frame_event, resp_code, flags,
                    output ready);
endinterface

// ===== design/dfr_front.sv =====
module dfr_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dfr_rx_if.sink          i_rx,
    input  logic            i_full,
    output logic            o_push,
    output dfr_pkg::t_entry o_entry
);
    import dfr_pkg::*;

    logic              r_coll,  n_coll;
    logic [LEN_W-1:0]  r_len,   n_len;
    logic [BYTE_W-1:0] r_rc,    n_rc;
    logic [FLAG_W-1:0] r_flags, n_flags;
    t_frame            r_store, v_frame;

    logic              accept;
    logic [LEN_W-1:0]  len_inc;
    logic [BYTE_W-1:0] csum;
    logic [BYTE_W-1:0] cmd;
    logic [BYTE_W-1:0] p3;
    logic              ok;
    logic              fwd;
    t_event            ev;

    assign i_rx.ready = !i_full;
    assign accept     = i_rx.valid && !i_full;
    assign o_push     = accept;

    always_comb begin
        n_coll  = r_coll;
        n_len   = r_len;
        n_rc    = r_rc;
        n_flags = r_flags;
        v_frame = r_store;
        len_inc = r_len;
        ok      = 1'b0;
        fwd     = 1'b0;
        ev      = EV_NONE;
        csum    = '0;
        cmd     = '0;
        p3      = '0;

        if (t_op'(i_rx.op) == OP_CLEAR) begin
            n_flags = r_flags & ~i_rx.clear_mask;
        end else if (!r_coll) begin
            if (i_rx.rx_byte == DELIM) begin
                v_frame[0] = i_rx.rx_byte;
                n_len      = LEN_W'(1);
                n_coll     = 1'b1;
            end
        end else begin
            if (r_len < LEN_W'(FRAME_BYTES)) begin
                v_frame[r_len[IDX_W-1:0]] = i_rx.rx_byte;
            end
            if (r_len <= LEN_W'(FRAME_BYTES)) begin
                len_inc = r_len + LEN_W'(1);
            end
            n_len = len_inc;

            // checksum covers command through the byte before the check byte
            for (int i = 1; i < POS_CSUM; i++) begin
                csum = csum ^ v_frame[i];
            end
            for (int i = 0; i < FRAME_BYTES; i++) begin
                if (i == POS_CMD) cmd = v_frame[i];
                if (i == POS_P3)  p3  = v_frame[i];
            end

            if (i_rx.rx_byte == DELIM) begin
                n_coll = 1'b0;
                n_len  = '0;
                ok     = (len_inc == LEN_W'(FRAME_BYTES)) && (csum == v_frame[POS_CSUM]);
                if (ok) begin
                    ev = EV_ACCEPT;
                    unique case (cmd)
                        CMD_RECOG: begin
                            n_rc = p3;
                            n_flags[FLG_RECOG] = 1'b1;
                            fwd = 1'b1;
                        end
                        CMD_ENROLL1: begin
                            n_rc = p3;
                            n_flags[FLG_ENROLL1] = 1'b1;
                            fwd = 1'b1;
                        end
                        CMD_ENROLL2: begin
                            n_rc = p3;
                            n_flags[FLG_ENROLL2] = 1'b1;
                            fwd = 1'b1;
                        end
                        CMD_ENROLL3: begin
                            n_rc = p3;
                            n_flags[FLG_ENROLL3] = 1'b1;
                            fwd = 1'b1;
                        end
                        CMD_DELETE: begin
                            n_flags[FLG_DELETE] = 1'b1;
                            fwd = 1'b1;
                        end
                        CMD_CANCEL: begin
                            fwd = 1'b0;
                        end
                        default: begin
                            fwd = 1'b0;
                        end
                    endcase
                end else begin
                    ev = EV_REJECT;
                end
            end
        end

        o_entry.fwd   = fwd;
        o_entry.ev    = ev;
        o_entry.rc    = n_rc;
        o_entry.flags = n_flags;
        o_entry.frame = v_frame;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coll  <= 1'b0;
            r_len   <= '0;
            r_rc    <= '0;
            r_flags <= '0;
        end else if (accept) begin
            r_coll  <= n_coll;
            r_len   <= n_len;
            r_rc    <= n_rc;
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_store <= v_frame;
        end
    end

endmodule

// ===== design/dfr_fifo.sv =====
module dfr_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dfr_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output dfr_pkg::t_entry o_head
);
    import dfr_pkg::*;

    t_entry             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_PTR_W:0]   r_count, n_count;

    assign o_full  = (r_count == (Q_PTR_W + 1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) n_count = r_count + 1'b1;
        if (!i_push && i_pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ===== design/dfr_back.sv =====
module dfr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  dfr_pkg::t_entry i_head,
    output logic            o_pop,
    dfr_tx_if.source        o_tx
);
    import dfr_pkg::*;

    logic [IDX_W-1:0] r_cnt;
    logic             is_last;
    logic             xfer;

    assign is_last = !i_head.fwd || (r_cnt == IDX_W'(FRAME_BYTES - 1));
    assign xfer    = o_tx.valid && o_tx.ready;
    assign o_pop   = xfer && is_last;

    assign o_tx.valid       = !i_empty;
    assign o_tx.is_forward  = i_head.fwd;
    assign o_tx.tx_byte     = i_head.fwd ? i_head.frame[r_cnt] : '0;
    assign o_tx.last        = is_last;
    assign o_tx.frame_event = i_head.ev;
    assign o_tx.resp_code   = i_head.rc;
    assign o_tx.flags       = i_head.flags;

    // byte index within a forwarded frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (xfer) begin
            if (is_last) r_cnt <= '0;
            else         r_cnt <= r_cnt + 1'b1;
        end
    end

endmodule

// ===== design/delimited_frame_receiver_xor_check_unit.sv =====
// Channel  Dir  Payload                                              Transfer
// i_rx     in   op, rx_byte, clear_mask                              valid & ready
// o_tx     out  is_forward, tx_byte, last, frame_event,              valid & ready
//               resp_code, flags
//
// One input transfer per cycle while the job queue has room (4 entries).
// A status job leaves in one output transfer; a forwarded frame leaves as 8 output
// transfers, one byte each, paced by the byte counter in the back end.
// Reset (i_rst_n low, synchronous) clears the parser, flags, return code and queue.
// A stalled o_tx only blocks i_rx once the queue fills.
module delimited_frame_receiver_xor_check_unit (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dfr_rx_if.sink   i_rx,
    dfr_tx_if.source o_tx
);
    import dfr_pkg::*;

    // front end: frame parsing, checksum, command decode, flag/return-code state
    logic   push;
    logic   full;
    t_entry entry;

    // back end: expands each queued job into its results
    logic   pop;
    logic   empty;
    t_entry head;

    dfr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_full  (full),
        .o_push  (push),
        .o_entry (entry)
    );

    // each entry carries a snapshot of the frame, so the parser may keep
    // overwriting its store while a forward is still draining
    dfr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    dfr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_tx    (o_tx)
    );

endmodule
